### design/ksar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksar_pkg: shared types and constants
// Field widths, stream packing, the token passed along the cell chain and the
// command bundle broadcast from the controller to every cell.
// ----------------------------------------------------------------------------
package ksar_pkg;

  localparam int unsigned CAR_W       = 6;
  localparam int unsigned SCORE_W     = 16;
  localparam int unsigned ENTRIES_DEF = 64;

  // stream packing, first field in the lowest bits
  localparam int unsigned TDATA_W = 24;
  localparam int unsigned CAR_LSB   = 0;
  localparam int unsigned SCORE_LSB = CAR_W;

  localparam logic [CAR_W-1:0] SORT_COUNT_RST = 6'd63;

  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // best candidate found so far in a scan
  typedef struct packed {
    logic               valid;
    logic [SCORE_W-1:0] key;
    logic [CAR_W-1:0]   car;
  } tok_t;

  typedef struct packed {
    logic               add_en;
    logic [CAR_W-1:0]   add_car;
    logic [SCORE_W-1:0] add_score;
    logic               mark_en;
    logic [CAR_W-1:0]   mark_car;
    logic               clear;
  } cell_cmd_t;

endpackage

### design/keyed_score_accumulate_and_rank_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_score_accumulate_and_rank_core: per-car score totals with ranking
// Add items update one car total in a row of cells; a finish item selects
// cars in ascending total order by passing a candidate down the cell chain.
// ----------------------------------------------------------------------------
// add item: one add item per cycle while no finish item is in progress
// finish item: for each rank the candidate passes through every cell of the
//   chain and is then emitted once the output register is free; after the
//   last rank a clear state zeroes the totals and marks, then the next item is taken
// reset clears every total and mark at once and sets sort_count to 63
module keyed_score_accumulate_and_rank_core #(
  parameter int unsigned ENTRIES = ksar_pkg::ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // car_number [5:0], score [21:6], zero [23:22]
  input  logic [ksar_pkg::TDATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // ranked_car [5:0], total_score [21:6], zero [23:22]
  output logic [ksar_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [ksar_pkg::CAR_W-1:0]    cfg_wdata_i
);

  ksar_pkg::cell_cmd_t           cmd;
  logic [ksar_pkg::CAR_W-1:0]    rank_n;
  ksar_pkg::tok_t                link [ENTRIES];

  // car 0 is never ranked and its total is never read, so it has no cell
  assign link[0] = '0;

  for (genvar g = 1; g < ENTRIES; g++) begin : g_cell
    ksar_cell #(
      .CAR_IDX(g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .rank_n_i(rank_n),
      .tok_i   (link[g-1]),
      .tok_o   (link[g])
    );
  end

  ksar_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .chain_tok_i  (link[ENTRIES-1]),
    .cmd_o        (cmd),
    .rank_n_o     (rank_n)
  );

endmodule

### design/ksar_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksar_cell: one car slot of the ranking chain
// Holds the total and emitted mark of one car; if unmarked and within rank_n,
// it passes the smaller of its total and the candidate on to the next cell.
// ----------------------------------------------------------------------------
module ksar_cell #(
  parameter int unsigned CAR_IDX = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ksar_pkg::cell_cmd_t         cmd_i,
  input  logic [ksar_pkg::CAR_W-1:0]  rank_n_i,
  input  ksar_pkg::tok_t              tok_i,
  output ksar_pkg::tok_t              tok_o
);

  localparam logic [ksar_pkg::CAR_W-1:0] Idx = CAR_IDX[ksar_pkg::CAR_W-1:0];

  logic [ksar_pkg::SCORE_W-1:0] total_q, total_d;
  logic                         mark_q, mark_d;
  ksar_pkg::tok_t               tok_q, tok_d;
  logic                         eligible;
  logic                         take;

  assign eligible = !mark_q && (Idx <= rank_n_i);
  // strict compare: on a tie the earlier (smaller) car keeps the slot
  assign take = eligible && (!tok_i.valid || (total_q < tok_i.key));

  always_comb begin
    total_d = total_q;
    mark_d  = mark_q;
    tok_d   = tok_i;
    if (take) begin
      tok_d.valid = 1'b1;
      tok_d.key   = total_q;
      tok_d.car   = Idx;
    end
    if (cmd_i.clear) begin
      total_d = '0;
      mark_d  = 1'b0;
    end else begin
      if (cmd_i.add_en && (cmd_i.add_car == Idx)) begin
        total_d = total_q + cmd_i.add_score;
      end
      if (cmd_i.mark_en && (cmd_i.mark_car == Idx)) begin
        mark_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      mark_q  <= 1'b0;
      tok_q   <= '0;
    end else begin
      total_q <= total_d;
      mark_q  <= mark_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

### design/ksar_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksar_ctrl: sequencer and stream ports
// Takes items, drives the cell commands, times the chain scans, registers the
// ranked results and holds the sort_count register.
// ----------------------------------------------------------------------------
module ksar_ctrl #(
  parameter int unsigned ENTRIES = ksar_pkg::ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ksar_pkg::TDATA_W-1:0]  s_axis_tdata,
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ksar_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [ksar_pkg::CAR_W-1:0]    cfg_wdata_i,
  input  ksar_pkg::tok_t                chain_tok_i,
  output ksar_pkg::cell_cmd_t           cmd_o,
  output logic [ksar_pkg::CAR_W-1:0]    rank_n_o
);

  localparam int unsigned CNT_W = $clog2(ENTRIES);
  localparam logic [CNT_W-1:0] ScanEnd = CNT_W'(ENTRIES - 2);
  localparam logic [ksar_pkg::CAR_W-1:0] MaxN = ksar_pkg::CAR_W'(ENTRIES - 1);
  localparam int unsigned PAD_W = ksar_pkg::TDATA_W - ksar_pkg::CAR_W - ksar_pkg::SCORE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_CLEAR
  } state_e;

  state_e                         state_q, state_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [ksar_pkg::CAR_W-1:0]     rank_q, rank_d;
  logic [ksar_pkg::CAR_W-1:0]     sort_count_q, sort_count_d;
  logic                           m_valid_q, m_valid_d;
  logic [ksar_pkg::CAR_W-1:0]     m_car_q, m_car_d;
  logic [ksar_pkg::SCORE_W-1:0]   m_score_q, m_score_d;
  logic                           m_last_q, m_last_d;
  logic                           accept;
  logic                           out_free;
  logic                           is_last;
  logic [ksar_pkg::CAR_W-1:0]     rank_n;
  logic [ksar_pkg::CAR_W-1:0]     in_car;
  logic [ksar_pkg::SCORE_W-1:0]   in_score;

  assign in_car   = s_axis_tdata[ksar_pkg::CAR_LSB +: ksar_pkg::CAR_W];
  assign in_score = s_axis_tdata[ksar_pkg::SCORE_LSB +: ksar_pkg::SCORE_W];

  assign rank_n   = (sort_count_q > MaxN) ? MaxN : sort_count_q;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign is_last  = (ksar_pkg::CAR_W'(rank_q + 1'b1) == rank_n);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rank_d       = rank_q;
    sort_count_d = cfg_we_i ? cfg_wdata_i : sort_count_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_car_d      = m_car_q;
    m_score_d    = m_score_q;
    m_last_d     = m_last_q;

    cmd_o           = '0;
    cmd_o.add_car   = in_car;
    cmd_o.add_score = in_score;
    cmd_o.mark_car  = chain_tok_i.car;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == ksar_pkg::MODE_ADD) begin
            cmd_o.add_en = 1'b1;
          end else if (rank_n == '0) begin
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_SCAN;
            cnt_d   = '0;
            rank_d  = '0;
          end
        end
      end
      ST_SCAN: begin
        // the counter follows the candidate through the registered cells to the chain end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ScanEnd) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          m_valid_d     = 1'b1;
          m_car_d       = chain_tok_i.car;
          m_score_d     = chain_tok_i.key;
          m_last_d      = is_last;
          cmd_o.mark_en = 1'b1;
          rank_d        = rank_q + 1'b1;
          cnt_d         = '0;
          state_d       = is_last ? ST_CLEAR : ST_SCAN;
        end
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      rank_q       <= '0;
      sort_count_q <= ksar_pkg::SORT_COUNT_RST;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      rank_q       <= rank_d;
      sort_count_q <= sort_count_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_car_q   <= m_car_d;
    m_score_q <= m_score_d;
    m_last_q  <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, m_score_q, m_car_q};
  assign m_axis_tlast  = m_last_q;
  assign rank_n_o      = rank_n;

endmodule

### tb/tb_keyed_score_accumulate_and_rank_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_score_accumulate_and_rank_core: self-checking stream testbench
// Feeds add and finish items and keeps its own copy of the per-car totals.
// On each finish item it ranks the cars and queues the expected results.
// Every ranked result is checked field by field. Phases change the ranking
// count and the idle and stall rates, and one phase holds off the output.
// ----------------------------------------------------------------------------
module tb_keyed_score_accumulate_and_rank_core;
  import ksar_pkg::*;

  localparam int unsigned ENTRIES    = ENTRIES_DEF;
  localparam time         CLK_PERIOD = 8ns;
  localparam int unsigned HOLD_CYCLES = 2000;

  typedef struct {
    logic               mode;
    logic [CAR_W-1:0]   car;
    logic [SCORE_W-1:0] score;
  } race_item_t;

  typedef struct {
    logic [CAR_W-1:0]   car;
    logic [SCORE_W-1:0] total;
    logic               last;
  } rank_entry_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata  = '0;
  logic               s_axis_tuser  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;
  logic               cfg_we_i      = 1'b0;
  logic [CAR_W-1:0]   cfg_wdata_i   = '0;

  // race items waiting for the driver and rankings waiting for the block
  race_item_t  pending_q[$];
  rank_entry_t rank_q[$];
  race_item_t  drv_item;

  // predictor copy of the block state
  logic [SCORE_W-1:0] car_totals[ENTRIES];
  logic [CAR_W-1:0]   sort_cnt_q = SORT_COUNT_RST;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_arm      = 1'b0;
  logic        hold_done     = 1'b0;
  int unsigned hold_left     = 0;

  int unsigned n_errors   = 0;
  int unsigned n_items_in = 0;
  int unsigned n_finish   = 0;
  int unsigned n_ranked   = 0;

  keyed_score_accumulate_and_rank_core #(
    .ENTRIES(ENTRIES)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // driver: presents the next pending item once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_item = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= drv_item.mode;
        s_axis_tdata  <= {{(TDATA_W - CAR_W - SCORE_W){1'b0}}, drv_item.score, drv_item.car};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long output hold, started by the first result after arming
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done && m_axis_tvalid) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // input side: update the totals, rank on a finish item
  always @(posedge clk_i) begin : predict
    logic [CAR_W-1:0]   in_car;
    logic [SCORE_W-1:0] in_score;
    logic [ENTRIES-1:0] placed;
    int unsigned        n;
    int unsigned        best;
    bit                 found;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      n_items_in++;
      in_car   = s_axis_tdata[CAR_LSB +: CAR_W];
      in_score = s_axis_tdata[SCORE_LSB +: SCORE_W];
      if (s_axis_tuser == MODE_ADD) begin
        if (in_car < ENTRIES) begin
          car_totals[in_car] = car_totals[in_car] + in_score;
        end
      end else begin
        n_finish++;
        n = (sort_cnt_q > ENTRIES - 1) ? ENTRIES - 1 : sort_cnt_q;
        placed = '0;
        for (int unsigned k = 0; k < n; k++) begin
          best  = 0;
          found = 1'b0;
          // strict compare keeps the smaller car number first on equal totals
          for (int unsigned c = 1; c <= n; c++) begin
            if (!placed[c] && (!found || car_totals[c] < car_totals[best])) begin
              best  = c;
              found = 1'b1;
            end
          end
          placed[best] = 1'b1;
          rank_q.push_back('{car: best[CAR_W-1:0], total: car_totals[best],
                             last: (k + 1 == n)});
        end
        foreach (car_totals[i]) car_totals[i] = '0;
      end
    end
  end

  // output side: compare with the oldest expected ranking entry
  always @(posedge clk_i) begin : check
    rank_entry_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_ranked++;
      if (rank_q.size() == 0) begin
        $display("%0t: unexpected result car %0d total %0d last %0b", $time,
                 m_axis_tdata[CAR_LSB +: CAR_W], m_axis_tdata[SCORE_LSB +: SCORE_W],
                 m_axis_tlast);
        n_errors <= n_errors + 1;
      end else begin
        want = rank_q.pop_front();
        if (m_axis_tdata[CAR_LSB +: CAR_W] !== want.car ||
            m_axis_tdata[SCORE_LSB +: SCORE_W] !== want.total ||
            m_axis_tlast !== want.last) begin
          $display("%0t: mismatch expected car %0d total %0d last %0b, got car %0d total %0d last %0b",
                   $time, want.car, want.total, want.last, m_axis_tdata[CAR_LSB +: CAR_W],
                   m_axis_tdata[SCORE_LSB +: SCORE_W], m_axis_tlast);
          n_errors <= n_errors + 1;
        end
      end
    end
  end

  task automatic push_item(logic mode, logic [CAR_W-1:0] car, logic [SCORE_W-1:0] score);
    pending_q.push_back('{mode: mode, car: car, score: score});
  endtask

  task automatic write_count(logic [CAR_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sort_cnt_q  = value;
  endtask

  // a finish item may produce nothing, so give the block time to settle
  task automatic wait_drained();
    while (pending_q.size() != 0 || s_axis_tvalid || rank_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (2 * ENTRIES + 8) @(negedge clk_i);
  endtask

  // races: runs of adds closed by a finish item, plus some loose items
  task automatic add_races(int unsigned target, logic [CAR_W-1:0] cnt);
    int unsigned        pushed;
    int unsigned        run_len;
    logic [CAR_W-1:0]   car;
    logic [SCORE_W-1:0] score;
    pushed = 0;
    while (pushed < target) begin
      if ($urandom_range(0, 99) < 85) begin
        run_len = $urandom_range(2, 12);
        for (int unsigned i = 0; i < run_len; i++) begin
          if (cnt != 0 && $urandom_range(0, 99) < 80) car = CAR_W'($urandom_range(1, cnt));
          else car = CAR_W'($urandom_range(0, (1 << CAR_W) - 1));
          case ($urandom_range(0, 5))
            0:       score = '0;
            1:       score = '1;
            2:       score = SCORE_W'($urandom_range(1, 9));
            default: score = SCORE_W'($urandom());
          endcase
          push_item(MODE_ADD, car, score);
        end
        push_item(MODE_FINISH, CAR_W'($urandom()), SCORE_W'($urandom()));
        pushed += run_len + 1;
      end else begin
        push_item($urandom_range(0, 1) ? MODE_FINISH : MODE_ADD, CAR_W'($urandom()),
                  SCORE_W'($urandom()));
        pushed++;
      end
    end
  endtask

  task automatic run_phase(logic [CAR_W-1:0] cnt, int unsigned s_idle, int unsigned r_idle,
                           int unsigned n_items);
    write_count(cnt);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    add_races(n_items, cnt);
    wait_drained();
  endtask

  initial begin
    foreach (car_totals[i]) car_totals[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset count, wrap of a total, tie on equal totals, car zero, last car
    push_item(MODE_ADD, 6'd1, 16'hFFFF);
    push_item(MODE_ADD, 6'd1, 16'h0002);
    push_item(MODE_ADD, 6'd2, 16'h0001);
    push_item(MODE_ADD, 6'd0, 16'h0005);
    push_item(MODE_ADD, 6'd63, 16'hFFFF);
    push_item(MODE_ADD, 6'd5, 16'h8000);
    push_item(MODE_ADD, 6'd62, 16'h0000);
    push_item(MODE_FINISH, 6'h3F, 16'hFFFF);
    // totals must be clear again: all tied at zero
    push_item(MODE_FINISH, 6'h00, 16'h0000);
    wait_drained();

    // count zero emits nothing but still clears
    write_count(6'd0);
    push_item(MODE_ADD, 6'd1, 16'h0007);
    push_item(MODE_FINISH, 6'h15, 16'h1234);
    wait_drained();

    write_count(6'd1);
    push_item(MODE_FINISH, 6'h2A, 16'h5555);
    push_item(MODE_ADD, 6'd2, 16'h000A);
    push_item(MODE_ADD, 6'd1, 16'hAAAA);
    push_item(MODE_ADD, 6'd1, 16'h5555);
    push_item(MODE_FINISH, 6'h00, 16'h0000);
    wait_drained();

    run_phase(6'd63, 0, 0, 60);
    run_phase(6'd12, 65, 0, 80);
    run_phase(6'd1, 0, 65, 80);
    run_phase(6'd30, 33, 33, 80);
    hold_arm = 1'b1;
    run_phase(6'd20, 0, 0, 40);
    run_phase(6'd5, 33, 33, 40);
    run_phase(6'd63, 33, 33, 30);

    $display("covered %0d items with %0d finish items and %0d ranked results checked",
             n_items_in, n_finish, n_ranked);
    $display("ranking counts 0, 1, 5, 12, 20, 30 and 63 under idle, stall and long output hold");
    if (n_errors == 0 && rank_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 10_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
design/ksar_pkg.sv
design/ksar_cell.sv
design/ksar_ctrl.sv
design/keyed_score_accumulate_and_rank_core.sv
tb/tb_keyed_score_accumulate_and_rank_core.sv
